// ===== rtl/core/stpr_pkg.sv =====
// Shared types and constants of the scrolling tilemap pixel renderer.
// Used by every module under rtl/core but stpr_ram; depends on nothing else.
package stpr_pkg;

  // Tile geometry and map limits.
  localparam int unsigned TILE_SIZE       = 16;
  localparam int unsigned TILE_W          = $clog2(TILE_SIZE);
  localparam int unsigned MAX_MAP_COLUMNS = 64;
  localparam int unsigned MAX_MAP_ROWS    = 64;
  localparam int unsigned COL_W           = $clog2(MAX_MAP_COLUMNS);
  localparam int unsigned ROW_W           = $clog2(MAX_MAP_ROWS);
  localparam int unsigned TILE_SLOTS      = 16;

  // Both stores are 4096 entries deep.
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned SLOT_W      = ADDR_W - 2 * TILE_W;
  localparam int unsigned MAP_DATA_W  = 16;
  localparam int unsigned PIX_W       = 32;

  localparam int unsigned OFS_W   = 11;
  localparam int unsigned SCR_W   = 12;
  localparam int unsigned WORLD_W = 13;

  localparam logic [PIX_W-1:0] TRANSPARENT_KEY = 32'hFF00_0000;

  // Result queue depth; it also bounds the number of transactions in flight.
  localparam int unsigned RES_FIFO_DEPTH = 8;

  typedef enum logic [1:0] {
    OP_MAP_WR  = 2'd0,
    OP_TILE_WR = 2'd1,
    OP_SCROLL  = 2'd2,
    OP_RENDER  = 2'd3
  } op_e;

  // Configuration register indexes (byte address is four times the index).
  localparam logic [2:0] REG_MAP_COLUMNS   = 3'd0;
  localparam logic [2:0] REG_MAP_ROWS_USED = 3'd1;
  localparam logic [2:0] REG_TILE_COUNT    = 3'd2;
  localparam logic [2:0] REG_VIEW_WIDTH    = 3'd3;
  localparam logic [2:0] REG_VIEW_HEIGHT   = 3'd4;

  typedef struct packed {
    logic [6:0]  map_columns;
    logic [6:0]  map_rows_used;
    logic [4:0]  tile_count;
    logic [11:0] view_width;
    logic [11:0] view_height;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_color;
    logic             pixel_drawn;
    logic [OFS_W-1:0] offset_x;
    logic [OFS_W-1:0] offset_y;
  } result_t;

endpackage

// ===== rtl/core/stpr_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// Stands alone; used for the map store and the tile store.
module stpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/stpr_res_fifo.sv =====
// Result queue between the render pipeline and the output channel.
// Depends on stpr_pkg for the result type and the queue depth.
module stpr_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stpr_pkg::result_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output stpr_pkg::result_t data_o
);
  import stpr_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_FIFO_DEPTH + 1);

  result_t          entry_q [RES_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/stpr_pipe.sv =====
// Scroll state and the three-stage render pipeline around the map and tile RAMs.
// Depends on stpr_pkg and stpr_ram.
module stpr_pipe (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stpr_pkg::cfg_t                      cfg_i,
  input  logic                                accept_i,
  input  logic [1:0]                          operation_i,
  input  logic [stpr_pkg::ADDR_W-1:0]         address_i,
  input  logic [stpr_pkg::PIX_W-1:0]          write_value_i,
  input  logic [stpr_pkg::SCR_W-1:0]          screen_x_i,
  input  logic [stpr_pkg::SCR_W-1:0]          screen_y_i,
  input  logic signed [stpr_pkg::SCR_W-1:0]   delta_x_i,
  input  logic signed [stpr_pkg::SCR_W-1:0]   delta_y_i,
  output logic                                res_valid_o,
  output stpr_pkg::result_t                   res_o,
  output logic                                retire_o
);
  import stpr_pkg::*;

  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
    logic [OFS_W-1:0]  ofs_x;
    logic [OFS_W-1:0]  ofs_y;
    logic              hit;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [TILE_W-1:0] px;
    logic [TILE_W-1:0] py;
  } s1_t;

  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
    logic [OFS_W-1:0]  ofs_x;
    logic [OFS_W-1:0]  ofs_y;
    logic              hit;
    logic [TILE_W-1:0] px;
    logic [TILE_W-1:0] py;
  } s2_t;

  typedef struct packed {
    logic             valid;
    op_e              op;
    logic             ok;
    logic [OFS_W-1:0] ofs_x;
    logic [OFS_W-1:0] ofs_y;
  } s3_t;

  // Clamp cur + delta to 0 .. cells * TILE_SIZE - view, or to 0 when the map
  // is narrower than the view.
  function automatic logic [OFS_W-1:0] scroll_axis(
    input logic [OFS_W-1:0]        cur,
    input logic signed [SCR_W-1:0] delta,
    input logic [6:0]              cells,
    input logic [SCR_W-1:0]        view
  );
    logic [13:0]        span;
    logic signed [13:0] hi;
    logic signed [13:0] v;
    span = 14'(cells) << TILE_W;
    hi   = signed'(span) - signed'(14'(view));
    v    = signed'(14'(cur)) + 14'(delta);
    if (hi < 0) begin
      hi = '0;
    end
    if (v > hi) begin
      v = hi;
    end
    if (v < 0) begin
      v = '0;
    end
    return v[OFS_W-1:0];
  endfunction

  op_e                in_op;
  logic [6:0]         cols_sat;
  logic [6:0]         rows_sat;
  logic [4:0]         tiles_sat;
  logic [OFS_W-1:0]   scroll_x_q, scroll_x_d;
  logic [OFS_W-1:0]   scroll_y_q, scroll_y_d;
  logic [WORLD_W-1:0] wx, wy;
  logic [WORLD_W-TILE_W-1:0] col_w, row_w;
  logic               on_screen, in_map;
  s1_t                s1_q, s1_d;
  s2_t                s2_q, s2_d;
  s3_t                s3_q, s3_d;
  logic [13:0]        map_idx;
  logic               map_we;
  logic [ADDR_W-1:0]  map_addr;
  logic [MAP_DATA_W-1:0] map_rdata;
  logic               tile_we;
  logic [ADDR_W-1:0]  tile_addr;
  logic [PIX_W-1:0]   tile_rdata;
  logic               drawn;

  assign in_op     = op_e'(operation_i);
  assign cols_sat  = (cfg_i.map_columns > 7'(MAX_MAP_COLUMNS)) ?
                     7'(MAX_MAP_COLUMNS) : cfg_i.map_columns;
  assign rows_sat  = (cfg_i.map_rows_used > 7'(MAX_MAP_ROWS)) ?
                     7'(MAX_MAP_ROWS) : cfg_i.map_rows_used;
  assign tiles_sat = (cfg_i.tile_count > 5'(TILE_SLOTS)) ? 5'(TILE_SLOTS) : cfg_i.tile_count;

  // Accept stage: scroll update and world position. Scroll state changes at
  // the accept edge, so later renders see it in transaction order.
  always_comb begin
    scroll_x_d = scroll_x_q;
    scroll_y_d = scroll_y_q;
    if (accept_i && in_op == OP_SCROLL) begin
      scroll_x_d = scroll_axis(scroll_x_q, delta_x_i, cols_sat, cfg_i.view_width);
      scroll_y_d = scroll_axis(scroll_y_q, delta_y_i, rows_sat, cfg_i.view_height);
    end
    wx        = WORLD_W'(scroll_x_q) + WORLD_W'(screen_x_i);
    wy        = WORLD_W'(scroll_y_q) + WORLD_W'(screen_y_i);
    col_w     = wx[WORLD_W-1:TILE_W];
    row_w     = wy[WORLD_W-1:TILE_W];
    on_screen = (screen_x_i < cfg_i.view_width) && (screen_y_i < cfg_i.view_height);
    in_map    = (col_w < (WORLD_W-TILE_W)'(cols_sat)) && (row_w < (WORLD_W-TILE_W)'(rows_sat));

    s1_d.valid = accept_i;
    s1_d.op    = in_op;
    s1_d.addr  = address_i;
    s1_d.wdata = write_value_i;
    s1_d.ofs_x = scroll_x_d;
    s1_d.ofs_y = scroll_y_d;
    s1_d.hit   = (in_op == OP_RENDER) && on_screen && in_map;
    s1_d.row   = row_w[ROW_W-1:0];
    s1_d.col   = col_w[COL_W-1:0];
    s1_d.px    = wx[TILE_W-1:0];
    s1_d.py    = wy[TILE_W-1:0];
  end

  // Map stage: map writes and map reads share one port in transaction order.
  always_comb begin
    map_idx  = 14'(s1_q.row) * 14'(cols_sat) + 14'(s1_q.col);
    map_we   = s1_q.valid && (s1_q.op == OP_MAP_WR);
    map_addr = map_we ? s1_q.addr : map_idx[ADDR_W-1:0];

    s2_d.valid = s1_q.valid;
    s2_d.op    = s1_q.op;
    s2_d.addr  = s1_q.addr;
    s2_d.wdata = s1_q.wdata;
    s2_d.ofs_x = s1_q.ofs_x;
    s2_d.ofs_y = s1_q.ofs_y;
    s2_d.hit   = s1_q.hit && (map_idx < 14'(STORE_DEPTH));
    s2_d.px    = s1_q.px;
    s2_d.py    = s1_q.py;
  end

  stpr_ram #(
    .WIDTH (MAP_DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (s1_q.wdata[MAP_DATA_W-1:0]),
    .rdata_o (map_rdata)
  );

  // Tile stage: the pixel address takes only the low bits of the map entry, so
  // it always fits the store; an entry at or above the tile count is not drawn.
  always_comb begin
    tile_we   = s2_q.valid && (s2_q.op == OP_TILE_WR);
    tile_addr = tile_we ? s2_q.addr : {map_rdata[SLOT_W-1:0], s2_q.py, s2_q.px};

    s3_d.valid = s2_q.valid;
    s3_d.op    = s2_q.op;
    s3_d.ok    = s2_q.hit && (map_rdata < MAP_DATA_W'(tiles_sat));
    s3_d.ofs_x = s2_q.ofs_x;
    s3_d.ofs_y = s2_q.ofs_y;
  end

  stpr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tile_we),
    .addr_i  (tile_addr),
    .wdata_i (s2_q.wdata),
    .rdata_o (tile_rdata)
  );

  // Result stage.
  assign drawn             = s3_q.ok && (tile_rdata != TRANSPARENT_KEY);
  assign res_valid_o       = s3_q.valid && ((s3_q.op == OP_SCROLL) || (s3_q.op == OP_RENDER));
  assign retire_o          = s3_q.valid && !res_valid_o;
  assign res_o.pixel_color = drawn ? tile_rdata : '0;
  assign res_o.pixel_drawn = drawn;
  assign res_o.offset_x    = s3_q.ofs_x;
  assign res_o.offset_y    = s3_q.ofs_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q <= '0;
      scroll_y_q <= '0;
      s1_q       <= '0;
      s2_q       <= '0;
      s3_q       <= '0;
    end else begin
      scroll_x_q <= scroll_x_d;
      scroll_y_q <= scroll_y_d;
      s1_q       <= s1_d;
      s2_q       <= s2_d;
      s3_q       <= s3_d;
    end
  end

`ifndef SYNTHESIS
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid |=> s2_q.valid) else $error("map stage lost a transaction");
  a_s2_to_s3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q.valid |=> s3_q.valid) else $error("tile stage lost a transaction");
  a_scroll_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scroll_x_q <= OFS_W'(MAX_MAP_COLUMNS * TILE_SIZE)) &&
    (scroll_y_q <= OFS_W'(MAX_MAP_ROWS * TILE_SIZE)))
    else $error("scroll offset beyond the largest map");
  a_no_key_drawn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.pixel_drawn) |-> (res_o.pixel_color != TRANSPARENT_KEY))
    else $error("transparent pixel marked as drawn");
`endif

endmodule

// ===== rtl/core/scrolling_tilemap_pixel_renderer.sv =====
// Scrolling tilemap pixel renderer: accepts one transaction per clock cycle
// while in_stall_o is low. A transaction passes an accept stage (scroll update,
// world position), a map stage (map RAM read or write) and a tile stage (tile
// RAM read or write); a result then enters the 8-entry result queue. The
// queue depth also limits the transactions in flight; input stall rises only
// when eight accepted transactions have not yet left the block. Map and tile
// writes produce no result. Configuration registers sit at byte addresses 0,
// 4, 8, 12 and 16; the user must write them while idle, which is not enforced.
module scrolling_tilemap_pixel_renderer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic [stpr_pkg::ADDR_W-1:0]        address_i,
  input  logic [stpr_pkg::PIX_W-1:0]         write_value_i,
  input  logic [stpr_pkg::SCR_W-1:0]         screen_x_i,
  input  logic [stpr_pkg::SCR_W-1:0]         screen_y_i,
  input  logic signed [stpr_pkg::SCR_W-1:0]  delta_x_i,
  input  logic signed [stpr_pkg::SCR_W-1:0]  delta_y_i,
  // Output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [stpr_pkg::PIX_W-1:0]         pixel_color_o,
  output logic                               pixel_drawn_o,
  output logic [stpr_pkg::OFS_W-1:0]         offset_x_o,
  output logic [stpr_pkg::OFS_W-1:0]         offset_y_o
);
  import stpr_pkg::*;

  localparam int unsigned CNT_W = $clog2(RES_FIFO_DEPTH + 1);

  cfg_t             cfg_q, cfg_d;
  logic             cfg_wr;
  logic [2:0]       reg_idx;
  logic             accept;
  logic             pop;
  logic             res_valid;
  result_t          res;
  logic             retire;
  result_t          head;
  logic [CNT_W-1:0] inflight_q, inflight_d;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAP_COLUMNS:   cfg_d.map_columns   = pwdata[6:0];
        REG_MAP_ROWS_USED: cfg_d.map_rows_used = pwdata[6:0];
        REG_TILE_COUNT:    cfg_d.tile_count    = pwdata[4:0];
        REG_VIEW_WIDTH:    cfg_d.view_width    = pwdata[11:0];
        REG_VIEW_HEIGHT:   cfg_d.view_height   = pwdata[11:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAP_COLUMNS:   prdata = 32'(cfg_q.map_columns);
      REG_MAP_ROWS_USED: prdata = 32'(cfg_q.map_rows_used);
      REG_TILE_COUNT:    prdata = 32'(cfg_q.tile_count);
      REG_VIEW_WIDTH:    prdata = 32'(cfg_q.view_width);
      REG_VIEW_HEIGHT:   prdata = 32'(cfg_q.view_height);
      default:           prdata = '0;
    endcase
  end

  // Every accepted transaction holds a credit until its result is taken or,
  // for a write, until it leaves the tile stage.
  assign in_stall_o = (inflight_q == CNT_W'(RES_FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign inflight_d = inflight_q + CNT_W'(accept) - CNT_W'(pop) - CNT_W'(retire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_columns   <= 7'd30;
      cfg_q.map_rows_used <= 7'd20;
      cfg_q.tile_count    <= 5'd0;
      cfg_q.view_width    <= 12'd800;
      cfg_q.view_height   <= 12'd600;
      inflight_q          <= '0;
    end else begin
      cfg_q      <= cfg_d;
      inflight_q <= inflight_d;
    end
  end

  stpr_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .address_i     (address_i),
    .write_value_i (write_value_i),
    .screen_x_i    (screen_x_i),
    .screen_y_i    (screen_y_i),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .retire_o      (retire)
  );

  stpr_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (!out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (head)
  );

  assign pixel_color_o = head.pixel_color;
  assign pixel_drawn_o = head.pixel_drawn;
  assign offset_x_o    = head.offset_x;
  assign offset_y_o    = head.offset_y;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(RES_FIFO_DEPTH)) else $error("in-flight count overflow");
  a_out_has_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != '0)) else $error("result without a transaction");
  a_accept_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (inflight_q != '0)) else $error("accepted transaction not counted");
`endif

endmodule

// ===== sim/scrolling_tilemap_pixel_renderer_tb.sv =====
// Self-checking testbench for the scrolling tilemap pixel renderer.
// Depends on rtl/core/stpr_pkg.sv and rtl/core/scrolling_tilemap_pixel_renderer.sv.
module scrolling_tilemap_pixel_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stpr_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int TILE        = TILE_SIZE;
  localparam int MAX_COLS    = MAX_MAP_COLUMNS;
  localparam int MAX_ROWS    = MAX_MAP_ROWS;
  localparam int SLOTS       = TILE_SLOTS;
  localparam int DEPTH       = STORE_DEPTH;
  localparam int OFS_LIMIT   = 2047;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 8;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i   = '0;
  logic [ADDR_W-1:0] address_i = '0;
  logic [PIX_W-1:0]  write_value_i = '0;
  logic [SCR_W-1:0]  screen_x_i = '0;
  logic [SCR_W-1:0]  screen_y_i = '0;
  logic signed [SCR_W-1:0] delta_x_i = '0;
  logic signed [SCR_W-1:0] delta_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [PIX_W-1:0] pixel_color_o;
  logic        pixel_drawn_o;
  logic [OFS_W-1:0] offset_x_o;
  logic [OFS_W-1:0] offset_y_o;

  // Shadow copy of the block state.
  cfg_t              cfg = '{7'd30, 7'd20, 5'd0, 12'd800, 12'd600};
  logic [15:0]       shadow_map   [DEPTH];
  logic [PIX_W-1:0]  shadow_tiles [DEPTH];
  bit                map_written  [DEPTH];
  bit                tile_written [DEPTH];
  logic [OFS_W-1:0]  ofs_x = '0;
  logic [OFS_W-1:0]  ofs_y = '0;

  result_t pending_pixels [$];
  int      mismatch_count = 0;
  logic    idle_enable    = 1'b1;

  scrolling_tilemap_pixel_renderer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .address_i     (address_i),
    .write_value_i (write_value_i),
    .screen_x_i    (screen_x_i),
    .screen_y_i    (screen_y_i),
    .delta_x_i     (delta_x_i),
    .delta_y_i     (delta_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o),
    .pixel_drawn_o (pixel_drawn_o),
    .offset_x_o    (offset_x_o),
    .offset_y_o    (offset_y_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic void add_expected(result_t r);
    pending_pixels = {pending_pixels, r};
  endfunction

  function automatic int clip(int v, int limit);
    return (v > limit) ? limit : v;
  endfunction

  // Map entries mostly point at valid tile slots.
  function automatic logic [PIX_W-1:0] map_value();
    return ($urandom_range(0, 3) == 0) ? $urandom
           : {16'($urandom), 16'($urandom_range(0, SLOTS - 1))};
  endfunction

  function automatic logic [PIX_W-1:0] pixel_value();
    return ($urandom_range(0, 7) == 0) ? TRANSPARENT_KEY : $urandom;
  endfunction

  function automatic logic [OFS_W-1:0] clamp_offset(logic [OFS_W-1:0] cur,
                                                    logic signed [SCR_W-1:0] delta,
                                                    int cells, int view);
    int hi;
    int pos;
    hi  = cells * TILE - view;
    pos = int'(cur) + int'(delta);
    if (hi < 0) hi = 0;
    if (pos > hi) pos = hi;
    if (pos < 0) pos = 0;
    return OFS_W'(clip(pos, OFS_LIMIT));
  endfunction

  function automatic logic lookup_pixel(input int sx, input int sy,
                                        output logic [PIX_W-1:0] color);
    int cols;
    int rows;
    int tiles;
    int wx;
    int wy;
    int map_idx;
    int tidx;
    int taddr;
    cols  = clip(int'(cfg.map_columns), MAX_COLS);
    rows  = clip(int'(cfg.map_rows_used), MAX_ROWS);
    tiles = clip(int'(cfg.tile_count), SLOTS);
    color = '0;
    if (sx >= int'(cfg.view_width) || sy >= int'(cfg.view_height)) return 1'b0;
    wx = int'(ofs_x) + sx;
    wy = int'(ofs_y) + sy;
    if (wx / TILE >= cols || wy / TILE >= rows) return 1'b0;
    map_idx = (wy / TILE) * cols + wx / TILE;
    if (map_idx >= DEPTH) return 1'b0;
    tidx = int'(shadow_map[map_idx]);
    if (tidx >= tiles) return 1'b0;
    taddr = tidx * TILE * TILE + (wy % TILE) * TILE + wx % TILE;
    if (taddr >= DEPTH) return 1'b0;
    if (shadow_tiles[taddr] == TRANSPARENT_KEY) return 1'b0;
    color = shadow_tiles[taddr];
    return 1'b1;
  endfunction

  // Drives one transaction and leaves valid high so the next one can follow
  // in the very next cycle.
  task automatic send_item(input op_e op, input logic [ADDR_W-1:0] addr,
                           input logic [PIX_W-1:0] value,
                           input logic [SCR_W-1:0] sx, input logic [SCR_W-1:0] sy,
                           input logic signed [SCR_W-1:0] dx,
                           input logic signed [SCR_W-1:0] dy);
    result_t          want;
    logic [PIX_W-1:0] color;
    logic             drawn;
    @(negedge clk_i);
    if (idle_enable && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    operation_i   <= op;
    address_i     <= addr;
    write_value_i <= value;
    screen_x_i    <= sx;
    screen_y_i    <= sy;
    delta_x_i     <= dx;
    delta_y_i     <= dy;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    case (op)
      OP_MAP_WR: begin
        shadow_map[addr]  = value[15:0];
        map_written[addr] = 1'b1;
      end
      OP_TILE_WR: begin
        shadow_tiles[addr] = value;
        tile_written[addr] = 1'b1;
      end
      default: begin
        color = '0;
        drawn = 1'b0;
        if (op == OP_SCROLL) begin
          ofs_x = clamp_offset(ofs_x, dx, clip(int'(cfg.map_columns), MAX_COLS),
                               int'(cfg.view_width));
          ofs_y = clamp_offset(ofs_y, dy, clip(int'(cfg.map_rows_used), MAX_ROWS),
                               int'(cfg.view_height));
        end else begin
          drawn = lookup_pixel(int'(sx), int'(sy), color);
        end
        want.pixel_color = color;
        want.pixel_drawn = drawn;
        want.offset_x    = ofs_x;
        want.offset_y    = ofs_y;
        add_expected(want);
      end
    endcase
  endtask

  task automatic write_map(input logic [ADDR_W-1:0] addr, input logic [PIX_W-1:0] value);
    send_item(OP_MAP_WR, addr, value, SCR_W'($urandom), SCR_W'($urandom),
              SCR_W'($urandom), SCR_W'($urandom));
  endtask

  task automatic write_tile(input logic [ADDR_W-1:0] addr, input logic [PIX_W-1:0] value);
    send_item(OP_TILE_WR, addr, value, SCR_W'($urandom), SCR_W'($urandom),
              SCR_W'($urandom), SCR_W'($urandom));
  endtask

  task automatic scroll_by(input logic [SCR_W-1:0] dx, input logic [SCR_W-1:0] dy);
    send_item(OP_SCROLL, ADDR_W'($urandom), $urandom, SCR_W'($urandom),
              SCR_W'($urandom), dx, dy);
  endtask

  // Loads any store entry that a render at (sx, sy) would read before it has
  // been written, so every render reads loaded data.
  task automatic load_reads(input int sx, input int sy);
    int cols;
    int rows;
    int tiles;
    int wx;
    int wy;
    int map_idx;
    int tidx;
    int taddr;
    cols  = clip(int'(cfg.map_columns), MAX_COLS);
    rows  = clip(int'(cfg.map_rows_used), MAX_ROWS);
    tiles = clip(int'(cfg.tile_count), SLOTS);
    if (sx >= int'(cfg.view_width) || sy >= int'(cfg.view_height)) return;
    wx = int'(ofs_x) + sx;
    wy = int'(ofs_y) + sy;
    if (wx / TILE >= cols || wy / TILE >= rows) return;
    map_idx = (wy / TILE) * cols + wx / TILE;
    if (map_idx >= DEPTH) return;
    if (!map_written[map_idx]) write_map(ADDR_W'(map_idx), map_value());
    tidx = int'(shadow_map[map_idx]);
    if (tidx >= tiles) return;
    taddr = tidx * TILE * TILE + (wy % TILE) * TILE + wx % TILE;
    if (taddr >= DEPTH) return;
    if (!tile_written[taddr]) write_tile(ADDR_W'(taddr), pixel_value());
  endtask

  task automatic render_at(input logic [SCR_W-1:0] sx, input logic [SCR_W-1:0] sy);
    load_reads(int'(sx), int'(sy));
    send_item(OP_RENDER, ADDR_W'($urandom), $urandom, sx, sy,
              SCR_W'($urandom), SCR_W'($urandom));
  endtask

  // Lowers valid and waits until every expected pixel is out; store writes
  // give no result, so a final drain wait lets the pipeline empty.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic is_write, input logic [2:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx, input logic [31:0] want);
    logic [31:0] rdata;
    apb_access(1'b0, idx, $urandom, rdata);
    if (rdata !== want) begin
      log_mismatch($sformatf("register %0d read %h expected %h", idx, rdata, want));
    end
  endtask

  task automatic set_reg(input logic [2:0] idx, input int value);
    logic [31:0] rdata;
    logic [31:0] masked;
    wait_idle();
    apb_access(1'b1, idx, 32'(value), rdata);
    masked = '0;
    case (idx)
      REG_MAP_COLUMNS:   begin masked = 32'(value) & 32'h7F;  cfg.map_columns   = masked[6:0]; end
      REG_MAP_ROWS_USED: begin masked = 32'(value) & 32'h7F;  cfg.map_rows_used = masked[6:0]; end
      REG_TILE_COUNT:    begin masked = 32'(value) & 32'h1F;  cfg.tile_count    = masked[4:0]; end
      REG_VIEW_WIDTH:    begin masked = 32'(value) & 32'hFFF; cfg.view_width    = masked[11:0]; end
      REG_VIEW_HEIGHT:   begin masked = 32'(value) & 32'hFFF; cfg.view_height   = masked[11:0]; end
      default: ;
    endcase
    check_reg(idx, masked);
  endtask

  // Reset values and scrolling on a map that is smaller than the view.
  task automatic test_reset_defaults();
    check_reg(REG_MAP_COLUMNS, 32'd30);
    check_reg(REG_MAP_ROWS_USED, 32'd20);
    check_reg(REG_TILE_COUNT, 32'd0);
    check_reg(REG_VIEW_WIDTH, 32'd800);
    check_reg(REG_VIEW_HEIGHT, 32'd600);
    scroll_by(12'sd2047, 12'sd2047);
    scroll_by(-12'sd2048, -12'sd2048);
  endtask

  // A short run of map and tile writes at the bottom of both stores.
  task automatic test_store_load();
    for (int i = 0; i < 32; i++) begin
      write_map(ADDR_W'(i), map_value());
    end
    for (int i = 0; i < 32; i++) begin
      write_tile(ADDR_W'(i), pixel_value());
    end
  endtask

  task automatic test_directed_cases();
    // No tile is valid while the tile count is zero.
    render_at(12'd0, 12'd0);
    set_reg(REG_TILE_COUNT, 31);
    // Transparent key, then the same pixel made visible.
    write_map(12'd0, 32'h0000_0000);
    write_tile(12'd0, TRANSPARENT_KEY);
    render_at(12'd0, 12'd0);
    write_tile(12'd0, 32'h00FF_FFFF);
    render_at(12'd0, 12'd0);
    // Tile indexes at and far past the tile count.
    write_map(12'd1, 32'hABCD_0010);
    render_at(12'd16, 12'd0);
    write_map(12'd2, 32'h0000_FFFF);
    render_at(12'd32, 12'd0);
    // Screen edges.
    render_at(12'd799, 12'd599);
    render_at(12'd800, 12'd0);
    render_at(12'd0, 12'd600);
    render_at(12'd4095, 12'd4095);
    // Small view: both clamp bounds.
    set_reg(REG_VIEW_WIDTH, 64);
    set_reg(REG_VIEW_HEIGHT, 48);
    scroll_by(12'sd2047, 12'sd2047);
    render_at(12'd63, 12'd47);
    scroll_by(-12'sd2048, -12'sd2048);
    render_at(12'd0, 12'd0);
    // Widest view: columns and rows past the map edge.
    set_reg(REG_VIEW_WIDTH, 4095);
    set_reg(REG_VIEW_HEIGHT, 4095);
    render_at(12'd480, 12'd0);
    render_at(12'd0, 12'd320);
    // Map size registers above the maximum saturate.
    set_reg(REG_MAP_COLUMNS, 127);
    set_reg(REG_MAP_ROWS_USED, 127);
    render_at(12'd1023, 12'd1023);
    render_at(12'd1024, 12'd0);
    scroll_by(12'sd2047, 12'sd2047);
    // An empty map draws nothing.
    set_reg(REG_MAP_COLUMNS, 0);
    render_at(12'd0, 12'd0);
    scroll_by(12'sd5, 12'sd5);
  endtask

  task automatic test_random_traffic();
    int settings [6][5] = '{'{64, 64, 16, 1, 1}, '{8, 6, 4, 100, 80},
                            '{1, 1, 1, 16, 16}, '{-1, 0, 0, 0, 0},
                            '{20, 10, 16, 1000, 700}, '{127, 127, 31, 4095, 4095}};
    int setting [5];
    int cols;
    int rows;
    int cells;
    int pick;
    int vw;
    int vh;
    for (int ph = 0; ph < 6; ph++) begin
      setting = settings[ph];
      if (setting[0] < 0) begin
        setting[0] = $urandom_range(0, 127);
        setting[1] = $urandom_range(0, 127);
        setting[2] = $urandom_range(0, 31);
        setting[3] = $urandom_range(1, 1100);
        setting[4] = $urandom_range(1, 1100);
      end
      // The last phase runs with no gaps on either side.
      if (ph == 5) idle_enable = 1'b0;
      set_reg(REG_MAP_COLUMNS, setting[0]);
      set_reg(REG_MAP_ROWS_USED, setting[1]);
      set_reg(REG_TILE_COUNT, setting[2]);
      set_reg(REG_VIEW_WIDTH, setting[3]);
      set_reg(REG_VIEW_HEIGHT, setting[4]);
      cols  = clip(setting[0], MAX_COLS);
      rows  = clip(setting[1], MAX_ROWS);
      cells = (cols * rows > 0) ? cols * rows : DEPTH;
      vw    = setting[3];
      vh    = setting[4];
      for (int n = 0; n < 50; n++) begin
        if (ph == 1 && n == 25) wait_idle();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          write_map(ADDR_W'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, cells - 1)),
                    map_value());
        end else if (pick < 20) begin
          write_tile(ADDR_W'($urandom), pixel_value());
        end else if (pick < 38) begin
          if ($urandom_range(0, 3) == 0) begin
            scroll_by(SCR_W'($urandom), SCR_W'($urandom));
          end else begin
            scroll_by(SCR_W'($urandom_range(0, 64) - 32), SCR_W'($urandom_range(0, 64) - 32));
          end
        end else if ($urandom_range(0, 99) < 85) begin
          render_at(SCR_W'($urandom_range(0, vw - 1)), SCR_W'($urandom_range(0, vh - 1)));
        end else begin
          render_at(SCR_W'($urandom), SCR_W'($urandom));
        end
      end
    end
  endtask

  // Output side: random stall bursts.
  initial begin : sink_stall
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 11);
      end
      out_stall_i <= (hold > 0);
    end
  end

  always @(posedge clk_i) begin : check_pixels
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.pixel_color = pixel_color_o;
      got.pixel_drawn = pixel_drawn_o;
      got.offset_x    = offset_x_o;
      got.offset_y    = offset_y_o;
      if (pending_pixels.size() == 0) begin
        log_mismatch($sformatf("result with nothing expected: color=%h drawn=%b ofs=(%0d,%0d)",
                               got.pixel_color, got.pixel_drawn, got.offset_x, got.offset_y));
      end else begin
        want = pending_pixels.pop_front();
        if (got.pixel_color !== want.pixel_color || got.pixel_drawn !== want.pixel_drawn ||
            got.offset_x !== want.offset_x || got.offset_y !== want.offset_y) begin
          log_mismatch($sformatf(
            "expected color=%h drawn=%b ofs=(%0d,%0d) got color=%h drawn=%b ofs=(%0d,%0d)",
            want.pixel_color, want.pixel_drawn, want.offset_x, want.offset_y,
            got.pixel_color, got.pixel_drawn, got.offset_x, got.offset_y));
        end
      end
    end
  end

  // Ends the run when no transaction of any kind moves for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_store_load();
    test_directed_cases();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/stpr_pkg.sv
rtl/core/stpr_ram.sv
rtl/core/stpr_res_fifo.sv
rtl/core/stpr_pipe.sv
rtl/core/scrolling_tilemap_pixel_renderer.sv
sim/scrolling_tilemap_pixel_renderer_tb.sv
